>>> rtl/core/fir51_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir51_pkg
// Shared widths and the Q1.15 coefficient table of the 51-tap FIR filter.
// ----------------------------------------------------------------------------
package fir51_pkg;

  localparam int unsigned TAPS        = 51;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned OUT_W       = 34;
  localparam int unsigned TAP_IDX_W   = $clog2(TAPS);
  localparam int unsigned BIT_IDX_W   = $clog2(SAMPLE_W);

  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [OUT_W-1:0]    acc_t;
  typedef logic [TAP_IDX_W-1:0]       tap_idx_t;
  typedef logic [BIT_IDX_W-1:0]       bit_idx_t;

  // Control from the sequencer to the accumulator
  typedef struct packed {
    logic     clear;
    logic     step;
    tap_idx_t tap;
    bit_idx_t bit_pos;
  } mac_ctl_t;

  // Coefficient of tap i, tap 0 weights the newest sample
  function automatic coef_t tap_coef(input tap_idx_t i);
    coef_t c;
    unique case (i)
      6'd0:  c = -16'sd622;   6'd1:  c = -16'sd5;     6'd2:  c = 16'sd345;
      6'd3:  c = 16'sd691;    6'd4:  c = -16'sd284;   6'd5:  c = -16'sd931;
      6'd6:  c = -16'sd82;    6'd7:  c = 16'sd499;    6'd8:  c = 16'sd1269;
      6'd9:  c = -16'sd744;   6'd10: c = -16'sd962;   6'd11: c = -16'sd487;
      6'd12: c = 16'sd936;    6'd13: c = 16'sd1657;   6'd14: c = -16'sd1212;
      6'd15: c = -16'sd688;   6'd16: c = -16'sd1369;  6'd17: c = 16'sd1979;
      6'd18: c = 16'sd1286;   6'd19: c = -16'sd1154;  6'd20: c = -16'sd319;
      6'd21: c = -16'sd3019;  6'd22: c = 16'sd4878;   6'd23: c = -16'sd2611;
      6'd24: c = 16'sd4051;   6'd25: c = 16'sd26064;  6'd26: c = 16'sd4051;
      6'd27: c = -16'sd2611;  6'd28: c = 16'sd4878;   6'd29: c = -16'sd3019;
      6'd30: c = -16'sd319;   6'd31: c = -16'sd1154;  6'd32: c = 16'sd1286;
      6'd33: c = 16'sd1979;   6'd34: c = -16'sd1369;  6'd35: c = -16'sd688;
      6'd36: c = -16'sd1212;  6'd37: c = 16'sd1657;   6'd38: c = 16'sd936;
      6'd39: c = -16'sd487;   6'd40: c = -16'sd962;   6'd41: c = -16'sd744;
      6'd42: c = 16'sd1269;   6'd43: c = 16'sd499;    6'd44: c = -16'sd82;
      6'd45: c = -16'sd931;   6'd46: c = -16'sd284;   6'd47: c = 16'sd691;
      6'd48: c = 16'sd345;    6'd49: c = -16'sd5;     6'd50: c = -16'sd622;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/fir51_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir51_delay
// Delay line of the last 51 samples. On a new sample the line shifts by one
// tap; while a sum runs tap 0 rotates one bit per step, and the line one tap
// after its last bit, so tap 0 always presents its current bit at the low end.
// ----------------------------------------------------------------------------
module fir51_delay (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      load,
  input  wire fir51_pkg::sample_t  sample,
  input  wire                      rot_bit,
  input  wire                      rot_tap,
  output logic                     cur_bit
);

  fir51_pkg::sample_t line_r [fir51_pkg::TAPS];

  // Shift in a sample, rotate bits within tap 0, or rotate taps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fir51_pkg::TAPS; i++) line_r[i] <= '0;
    end else if (load) begin
      line_r[0] <= sample;
      for (int i = 1; i < fir51_pkg::TAPS; i++) line_r[i] <= line_r[i-1];
    end else if (rot_tap) begin
      for (int i = 0; i < fir51_pkg::TAPS - 1; i++) line_r[i] <= line_r[i+1];
      line_r[fir51_pkg::TAPS-1] <= {line_r[0][0], line_r[0][fir51_pkg::SAMPLE_W-1:1]};
    end else if (rot_bit) begin
      line_r[0] <= {line_r[0][0], line_r[0][fir51_pkg::SAMPLE_W-1:1]};
    end
  end

  assign cur_bit = line_r[0][0];

endmodule
`default_nettype wire

>>> rtl/core/fir51_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir51_mac
// Bit-serial multiply-accumulate: per step add the coefficient, shifted to
// the current sample bit, when that bit is set.
// ----------------------------------------------------------------------------
module fir51_mac (
  input  wire                     clk,
  input  wire fir51_pkg::mac_ctl_t ctl,
  input  wire                     sbit,
  output fir51_pkg::acc_t         acc
);

  fir51_pkg::acc_t acc_r;
  fir51_pkg::acc_t addend;

  // Coefficient aligned to the sample bit
  always_comb begin
    addend = fir51_pkg::acc_t'(fir51_pkg::tap_coef(ctl.tap)) <<< ctl.bit_pos;
  end

  // Clear or accumulate
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.step && sbit) begin
      acc_r <= acc_r + addend;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

>>> rtl/core/fir_filter_51_tap_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_filter_51_tap_unit
// 51-tap FIR filter over unsigned 12-bit samples, exact Q.15 output.
// ----------------------------------------------------------------------------
// Each accepted sample is handled by bit-serial multiply-accumulate over all
// 51 taps and all 12 sample bits, after a load and before a step that registers
// the result: one sample bit of one tap is handled per cycle, set by the single
// shift-add accumulator. out_valid rises as the result is registered. The result
// waits in an output register; in_ready is low while a sum runs or an unread
// result is held, so a new sample is taken only once the last result has been
// read.
module fir_filter_51_tap_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire  [11:0] in_sample,
  input  wire         in_valid,
  output logic        in_ready,
  output logic signed [33:0] out_filtered,
  output logic        out_valid,
  input  wire         out_ready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  fir51_pkg::tap_idx_t  tap_r, tap_nxt;
  fir51_pkg::bit_idx_t  bit_r, bit_nxt;
  logic                 ov_r, ov_nxt;
  fir51_pkg::acc_t      res_r;
  fir51_pkg::acc_t      acc;
  fir51_pkg::mac_ctl_t  ctl;
  logic                 load, last_bit, running, cur_bit;

  assign in_ready = (state_r == ST_IDLE) && !ov_r;
  assign load     = in_valid && in_ready;
  assign running  = (state_r == ST_RUN);
  assign last_bit = (bit_r == fir51_pkg::bit_idx_t'(fir51_pkg::SAMPLE_W - 1));

  assign ctl.clear   = load;
  assign ctl.step    = running;
  assign ctl.tap     = tap_r;
  assign ctl.bit_pos = bit_r;

  fir51_delay u_delay (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .sample  (in_sample),
    .rot_bit (running && !last_bit),
    .rot_tap (running && last_bit),
    .cur_bit (cur_bit)
  );

  fir51_mac u_mac (
    .clk  (clk),
    .ctl  (ctl),
    .sbit (cur_bit),
    .acc  (acc)
  );

  // Sequence taps and bits
  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    bit_nxt   = bit_r;
    ov_nxt    = ov_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          state_nxt = ST_RUN;
          tap_nxt   = '0;
          bit_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (last_bit) begin
          bit_nxt = '0;
          if (tap_r == fir51_pkg::tap_idx_t'(fir51_pkg::TAPS - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            tap_nxt = tap_r + 1'b1;
          end
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
        ov_nxt    = 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= '0;
      bit_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      bit_r   <= bit_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Hold the finished sum for transfer
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) res_r <= acc;
  end

  assign out_valid    = ov_r;
  assign out_filtered = res_r;

endmodule
`default_nettype wire

>>> rtl/core/fir51_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir51_check
// Port-level checks of the filter's handshakes.
// ----------------------------------------------------------------------------
module fir51_check (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [33:0] out_filtered
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered))
    else $error("result dropped or changed while stalled");

  a_no_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("no computation after transfer");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind fir_filter_51_tap_unit fir51_check u_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_filtered (out_filtered)
);
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 51-tap FIR filter unit: a local delay line and
// Q1.15 tap table predict each filtered output, compared in transfer order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_TAPS   = 51;
  localparam int ITEM_CYC   = 620;
  localparam int CYCLE_CAP  = 3000000;

  logic clk;
  logic rst_n;
  logic [11:0] in_sample;
  logic in_valid;
  logic in_ready;
  logic signed [33:0] out_filtered;
  logic out_valid;
  logic out_ready;

  fir_filter_51_tap_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_sample(in_sample), .in_valid(in_valid),
    .in_ready(in_ready), .out_filtered(out_filtered), .out_valid(out_valid),
    .out_ready(out_ready)
  );

  // Own copy of the Q1.15 taps, tap 0 weights the newest sample
  int signed tap_weight [NUM_TAPS] = '{
    -622, -5, 345, 691, -284, -931, -82, 499, 1269, -744,
    -962, -487, 936, 1657, -1212, -688, -1369, 1979, 1286, -1154,
    -319, -3019, 4878, -2611, 4051, 26064, 4051, -2611, 4878, -3019,
    -319, -1154, 1286, 1979, -1369, -688, -1212, 1657, 936, -487,
    -962, -744, 1269, 499, -82, -931, -284, 691, 345, -5, -622};

  logic [11:0] history [NUM_TAPS];
  int          hist_head;
  logic [11:0] pending_samples [$];
  logic signed [33:0] expected_filtered [$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  bit  quiet_phase;
  bit  hold_off_req;
  bit  pause_req;
  int  hold_left;

  // Shift a sample into the delay line and return the exact sum
  function automatic logic signed [33:0] filter_sample(input logic [11:0] s);
    longint sum;
    int idx;
    sum = 0;
    history[hist_head] = s;
    for (int i = 0; i < NUM_TAPS; i++) begin
      idx = (hist_head + NUM_TAPS - i) % NUM_TAPS;
      sum += longint'(tap_weight[i]) * longint'(history[idx]);
    end
    hist_head = (hist_head + 1) % NUM_TAPS;
    return sum[33:0];
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Driver: offer queued samples, idle at random outside the quiet phase
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_sample <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_filtered.push_back(filter_sample(in_sample));
      if (pending_samples.size() > 0 && !pause_req &&
          (quiet_phase || $urandom_range(99) >= 13)) begin
        in_valid  <= 1'b1;
        in_sample <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer, stall at random or for a long hold
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_filtered.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %0d", out_filtered);
        end else if (out_filtered !== expected_filtered[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %0d got %0d", expected_filtered[0],
                     out_filtered);
          void'(expected_filtered.pop_front());
        end else begin
          void'(expected_filtered.pop_front());
        end
      end
      if (hold_off_req && hold_left == 0) hold_left <= 3 * ITEM_CYC;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      out_ready <= (hold_left == 0 && !hold_off_req) &&
                   (quiet_phase || $urandom_range(99) >= 13);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sample at the falling edge so that all transfers of the cycle have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() > 0 || in_valid || expected_filtered.size() > 0);
  endtask

  initial begin
    int burst;
    rst_n = 0;
    quiet_phase = 0; hold_off_req = 0; pause_req = 0;
    hist_head = 0;
    for (int i = 0; i < NUM_TAPS; i++) history[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // Directed: start-up impulse, extremes, alternating bit patterns
    pending_samples.push_back(12'hFFF);
    pending_samples.push_back(12'h000);
    pending_samples.push_back(12'h001);
    pending_samples.push_back(12'hAAA);
    pending_samples.push_back(12'h555);
    for (int i = 0; i < 12; i++) pending_samples.push_back(12'hFFF);
    for (int i = 0; i < 6; i++) pending_samples.push_back(12'h000);
    wait_drained();

    // Sender pause once all queued samples are drained, then receiver hold-off
    pause_req = 1;
    repeat (5) @(posedge clk);
    pause_req = 0;
    hold_off_req = 1;
    for (int i = 0; i < 6; i++) pending_samples.push_back(12'($urandom_range(4095)));
    wait (hold_left > 0);
    hold_off_req = 0;
    wait_drained();

    // Quiet stretch: no idling on either side
    quiet_phase = 1;
    for (int i = 0; i < 60; i++) pending_samples.push_back(12'($urandom_range(4095)));
    wait_drained();
    quiet_phase = 0;

    // Random bursts: rails, small noise around mid-scale and uniform noise
    for (int n = 0; n < 460; n += burst) begin
      burst = $urandom_range(5, 30);
      for (int i = 0; i < burst; i++) begin
        case ($urandom_range(3))
          0: pending_samples.push_back($urandom_range(1) ? 12'hFFF : 12'h000);
          1: pending_samples.push_back(12'(12'h800 + $urandom_range(255) - 128));
          default: pending_samples.push_back(12'($urandom_range(4095)));
        endcase
      end
      wait_drained();
    end

    repeat (ITEM_CYC) @(posedge clk);
    $display("covered %0d filter outputs: impulses, rails, bit patterns, noise",
             results_seen);
    $display("with random stalls, a long output hold-off and a drained pause");
    if (mismatches == 0 && expected_filtered.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/fir51_pkg.sv
rtl/core/fir51_delay.sv
rtl/core/fir51_mac.sv
rtl/core/fir_filter_51_tap_unit.sv
rtl/core/fir51_check.sv
sim/tb_top.sv
